### sv/gwms_pkg.sv
// shared types, constants and the mismatch count for the guide window scan
`timescale 1ns / 1ps
package gwms_pkg;

    localparam int STORE_GUIDES      = 128;
    localparam int SLICE_GUIDES      = 32;
    localparam int SPACER_BYTE_COUNT = 5;

    localparam int BASES_W    = 40;
    localparam int IDX_W      = 7;
    localparam int SLICE_W    = 5;
    localparam int CNT_W      = 5;
    localparam int NUC_MAX    = BASES_W / 2;
    localparam int NUC_BYTES  = SPACER_BYTE_COUNT * 4;
    localparam int NUC        = (NUC_BYTES < NUC_MAX) ? NUC_BYTES : NUC_MAX;
    localparam int RESULT_MAX = 32;
    localparam int RESULT_CNT = (SLICE_GUIDES < RESULT_MAX) ? SLICE_GUIDES : RESULT_MAX;
    localparam int K_W        = (RESULT_CNT > 1) ? $clog2(RESULT_CNT) : 1;
    localparam int ADDR_W     = (STORE_GUIDES > 1) ? $clog2(STORE_GUIDES) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_WINDOW = 1'b1;

    // one classified item on its way from front to back
    typedef struct packed {
        logic               is_load;
        logic [IDX_W-1:0]   index;
        logic [BASES_W-1:0] bases;
        logic               last_window;
    } t_cmd;

    typedef struct packed {
        logic [SLICE_W-1:0] slice_guide;
        logic [CNT_W-1:0]   mismatches;
        logic               last;
        logic               chunk_done;
    } t_result;

    // a position mismatches when either of its two code bits differs
    function automatic logic [CNT_W-1:0] f_mismatches(input logic [BASES_W-1:0] a,
                                                      input logic [BASES_W-1:0] b);
        logic [BASES_W-1:0] d;
        logic [CNT_W-1:0]   total;
        d     = a ^ b;
        total = '0;
        for (int i = 0; i < NUC; i++) begin
            total = total + CNT_W'(d[2*i] | d[2*i+1]);
        end
        return total;
    endfunction

endpackage

### sv/gwms_front.sv
// front stage: takes input transfers and classifies them into load or window commands
`timescale 1ns / 1ps
module gwms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [gwms_pkg::IDX_W-1:0]    i_guide_index,
    input  logic [gwms_pkg::BASES_W-1:0]  i_guide_bases,
    input  logic [gwms_pkg::BASES_W-1:0]  i_window_bases,
    input  logic                          i_last_window,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output gwms_pkg::t_cmd                o_push_cmd
);
    import gwms_pkg::*;

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic take;

    always_comb begin
        o_ready = !r_valid || i_push_ready;
        take    = i_valid && o_ready;
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid             = 1'b1;
            n_cmd.is_load       = (i_mode == MODE_LOAD);
            n_cmd.index         = i_guide_index;
            n_cmd.bases         = (i_mode == MODE_LOAD) ? i_guide_bases : i_window_bases;
            n_cmd.last_window   = i_last_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

### sv/gwms_queue.sv
// short command queue between the front and back stages
`timescale 1ns / 1ps
module gwms_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  gwms_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output gwms_pkg::t_cmd o_pop_cmd
);
    import gwms_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_cnt;
    logic                push, pop;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_cnt != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_slot[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= f_next(r_wptr);
            end
            if (pop) begin
                r_rptr <= f_next(r_rptr);
            end
            priority if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

### sv/gwms_back.sv
// back stage: guide store, slice scan sequencer, mismatch count and output register
`timescale 1ns / 1ps
module gwms_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gwms_pkg::IDX_W-1:0]  i_cfg_data,
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  gwms_pkg::t_cmd              i_q_cmd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output gwms_pkg::t_result           o_result
);
    import gwms_pkg::*;

    logic [BASES_W-1:0] r_store [STORE_GUIDES];

    logic [IDX_W-1:0]   r_base;
    logic               r_busy;
    logic [K_W-1:0]     r_k;
    logic [BASES_W-1:0] r_win;
    logic               r_lastw;

    // read stage
    logic               r_s1_valid;
    logic [BASES_W-1:0] r_rd_data;
    logic [BASES_W-1:0] r_s1_win;
    logic [K_W-1:0]     r_s1_k;
    logic               r_s1_last;
    logic               r_s1_chunk;

    logic               r_out_valid;
    t_result            r_out;

    logic               out_free, issue, last_k, pop;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        issue    = r_busy && (!r_s1_valid || out_free);
        last_k   = (r_k == K_W'(RESULT_CNT - 1));
        // next command can enter on the cycle the last read of a window issues
        pop      = i_q_valid && (!r_busy || (issue && last_k));
        // store depth is a power of two, so the slot index wraps by truncation
        rd_addr  = ADDR_W'(r_base) + ADDR_W'(r_k);
        wr_addr  = ADDR_W'(i_q_cmd.index);
    end

    assign o_q_ready = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            priority if (pop && !i_q_cmd.is_load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (issue && last_k) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= r_k;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !i_q_cmd.is_load) begin
            r_win   <= i_q_cmd.bases;
            r_lastw <= i_q_cmd.last_window;
        end
        if (issue) begin
            r_s1_win   <= r_win;
            r_s1_k     <= r_k;
            r_s1_last  <= last_k;
            r_s1_chunk <= last_k && r_lastw;
        end
        if (r_s1_valid && out_free) begin
            r_out.slice_guide <= SLICE_W'(r_s1_k);
            r_out.mismatches  <= f_mismatches(r_rd_data, r_s1_win);
            r_out.last        <= r_s1_last;
            r_out.chunk_done  <= r_s1_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_cmd.is_load) begin
            r_store[wr_addr] <= i_q_cmd.bases;
        end
        if (issue) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_chunk_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.chunk_done |-> r_out.last)
        else $error("chunk_done without last");

    a_window_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_q_cmd.is_load |=> r_busy && r_k == '0)
        else $error("window did not start its scan");

    a_no_pop_mid_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !(issue && last_k) |-> !pop)
        else $error("command taken during a scan");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && last_k && !pop |=> !r_busy)
        else $error("scan kept running past its last guide");

endmodule

### sv/guide_window_mismatch_scan_top.sv
// top level of the guide window mismatch scan
`timescale 1ns / 1ps
// Input channel (i_valid / o_ready) carries one item per transfer. A load item
// (i_mode 0) writes i_guide_bases into guide slot i_guide_index and gives no
// result. A window item (i_mode 1) compares i_window_bases against the 32
// guides starting at the configured base slot (wrapping around the 128-slot
// store) and gives 32 results, one per guide in slice order, on the output
// channel (o_valid / i_ready). The final result of a window has o_last set,
// and o_chunk_done too when the window came with i_last_window.
// The user must write the base slot (i_cfg_we / i_cfg_data) only while idle;
// the block does not enforce this. Windows pass the front register, command
// queue, scan sequencer, read stage and output register. The back stage
// reads one guide per cycle from the single store read port unless the
// output stalls; waiting items sit in a front register and a two-entry queue.
// Reset clears the control state and sets the base slot to 0; the guide store
// is not cleared and a slot must be loaded before a window reads it.
// When the receiver stalls, the output and read stages hold and the scan
// pauses without losing or repeating any result.
module guide_window_mismatch_scan_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gwms_pkg::IDX_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [gwms_pkg::IDX_W-1:0]    i_guide_index,
    input  logic [gwms_pkg::BASES_W-1:0]  i_guide_bases,
    input  logic [gwms_pkg::BASES_W-1:0]  i_window_bases,
    input  logic                          i_last_window,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gwms_pkg::SLICE_W-1:0]  o_slice_guide,
    output logic [gwms_pkg::CNT_W-1:0]    o_mismatches,
    output logic                          o_last,
    output logic                          o_chunk_done
);
    import gwms_pkg::*;

    logic    push_valid, push_ready, q_valid, q_ready;
    t_cmd    push_cmd, q_cmd;
    t_result result;

    gwms_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_guide_index  (i_guide_index),
        .i_guide_bases  (i_guide_bases),
        .i_window_bases (i_window_bases),
        .i_last_window  (i_last_window),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_cmd     (push_cmd)
    );

    gwms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    gwms_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_cmd    (q_cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_slice_guide = result.slice_guide;
    assign o_mismatches  = result.mismatches;
    assign o_last        = result.last;
    assign o_chunk_done  = result.chunk_done;

endmodule

### dv/gwms_checker.sv
// checker for the guide window scan: watches both channels, predicts results and compares
`timescale 1ns / 1ps
module gwms_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gwms_pkg::IDX_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_mode,
    input  logic [gwms_pkg::IDX_W-1:0]   i_guide_index,
    input  logic [gwms_pkg::BASES_W-1:0] i_guide_bases,
    input  logic [gwms_pkg::BASES_W-1:0] i_window_bases,
    input  logic                         i_last_window,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [gwms_pkg::SLICE_W-1:0] i_slice_guide,
    input  logic [gwms_pkg::CNT_W-1:0]   i_mismatches,
    input  logic                         i_last,
    input  logic                         i_chunk_done,
    output int                           o_failures,
    output int                           o_pending,
    output int                           o_results
);
    import gwms_pkg::*;

    localparam int PRINT_MAX = 30;

    logic [BASES_W-1:0] guide_copy [STORE_GUIDES];
    logic [IDX_W-1:0]   slice_base;
    t_result            score_q [$];
    int                 failure_count = 0;
    int                 pending_count = 0;
    int                 result_count  = 0;

    assign o_failures = failure_count;
    assign o_pending  = pending_count;
    assign o_results  = result_count;

    // fold each 2-bit code onto its low bit, then count the flagged positions
    function automatic logic [CNT_W-1:0] nucleotide_diffs(input logic [BASES_W-1:0] guide,
                                                          input logic [BASES_W-1:0] window);
        logic [BASES_W-1:0] diff;
        logic [BASES_W-1:0] pair_hits;
        diff      = guide ^ window;
        pair_hits = (diff | (diff >> 1)) & {NUC{2'b01}};
        return CNT_W'($countones(pair_hits));
    endfunction

    task automatic report(input string msg);
        failure_count++;
        if (failure_count <= PRINT_MAX) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : scan_model
        t_result          want;
        logic [IDX_W-1:0] slot;
        if (!i_rst_n) begin
            slice_base = '0;
        end else begin
            if (i_cfg_we) begin
                slice_base = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == MODE_LOAD) begin
                    guide_copy[i_guide_index] = i_guide_bases;
                end else begin
                    for (int k = 0; k < RESULT_CNT; k++) begin
                        slot             = slice_base + IDX_W'(k);
                        want.slice_guide = SLICE_W'(k);
                        want.mismatches  = nucleotide_diffs(guide_copy[slot], i_window_bases);
                        want.last        = (k == RESULT_CNT - 1);
                        want.chunk_done  = want.last && i_last_window;
                        score_q.push_back(want);
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (score_q.size() == 0) begin
                    report($sformatf("result for slice guide %0d with nothing expected",
                                     i_slice_guide));
                end else begin
                    want = score_q.pop_front();
                    if (i_slice_guide !== want.slice_guide) begin
                        report($sformatf("slice_guide got %0d want %0d",
                                         i_slice_guide, want.slice_guide));
                    end
                    if (i_mismatches !== want.mismatches) begin
                        report($sformatf("mismatches for slice guide %0d got %0d want %0d",
                                         want.slice_guide, i_mismatches, want.mismatches));
                    end
                    if (i_last !== want.last) begin
                        report($sformatf("last for slice guide %0d got %0b want %0b",
                                         want.slice_guide, i_last, want.last));
                    end
                    if (i_chunk_done !== want.chunk_done) begin
                        report($sformatf("chunk_done for slice guide %0d got %0b want %0b",
                                         want.slice_guide, i_chunk_done, want.chunk_done));
                    end
                end
            end
        end
        pending_count = score_q.size();
    end

endmodule

### dv/guide_window_mismatch_scan_top_tb.sv
// testbench top for the guide window scan: stimulus, flow control and verdict
`timescale 1ns / 1ps
module guide_window_mismatch_scan_top_tb;
    import gwms_pkg::*;

    localparam int ITEM_TARGET   = 410;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_mode;
    logic [IDX_W-1:0]   i_guide_index;
    logic [BASES_W-1:0] i_guide_bases;
    logic [BASES_W-1:0] i_window_bases;
    logic               i_last_window;
    logic               o_valid;
    logic               i_ready;
    logic [SLICE_W-1:0] o_slice_guide;
    logic [CNT_W-1:0]   o_mismatches;
    logic               o_last;
    logic               o_chunk_done;

    int failures;
    int pending;
    int results;

    // stimulus bookkeeping: what each slot holds and which slice is selected
    logic [BASES_W-1:0] loaded_guide [STORE_GUIDES];
    logic [IDX_W-1:0]   slice_base    = '0;
    int                 items_sent    = 0;
    int                 windows_sent  = 0;
    int                 base_writes   = 0;
    int                 send_stretch  = 0;
    int                 recv_stretch  = 0;
    int                 cycle_count   = 0;

    guide_window_mismatch_scan_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_guide_index  (i_guide_index),
        .i_guide_bases  (i_guide_bases),
        .i_window_bases (i_window_bases),
        .i_last_window  (i_last_window),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slice_guide  (o_slice_guide),
        .o_mismatches   (o_mismatches),
        .o_last         (o_last),
        .o_chunk_done   (o_chunk_done)
    );

    gwms_checker scan_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_mode         (i_mode),
        .i_guide_index  (i_guide_index),
        .i_guide_bases  (i_guide_bases),
        .i_window_bases (i_window_bases),
        .i_last_window  (i_last_window),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_slice_guide  (o_slice_guide),
        .i_mismatches   (o_mismatches),
        .i_last         (o_last),
        .i_chunk_done   (o_chunk_done),
        .o_failures     (failures),
        .o_pending      (pending),
        .o_results      (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
            $display("guide_window_mismatch_scan_top_tb NOT OK");
            $finish;
        end
    end

    // wait cycles before the next item, with occasional stretches of none at all
    function automatic int draw_wait(inout int stretch_left);
        if (stretch_left > 0) begin
            stretch_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            stretch_left = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [BASES_W-1:0] rand_bases();
        return BASES_W'({$urandom(), $urandom()});
    endfunction

    // copy of a loaded guide with a chosen number of nucleotides changed
    function automatic logic [BASES_W-1:0] near_window(input logic [IDX_W-1:0] slot,
                                                       input int flips);
        logic [NUC-1:0]     flip_mask;
        logic [BASES_W-1:0] bases;
        flip_mask = '0;
        bases     = loaded_guide[slot];
        while ($countones(flip_mask) < flips) begin
            flip_mask[$urandom_range(0, NUC - 1)] = 1'b1;
        end
        for (int p = 0; p < NUC; p++) begin
            if (flip_mask[p]) begin
                bases[2*p +: 2] = bases[2*p +: 2] ^ 2'($urandom_range(1, 3));
            end
        end
        return bases;
    endfunction

    function automatic logic [BASES_W-1:0] pick_window();
        int flips;
        if ($urandom_range(0, 4) >= 3) begin
            return rand_bases();
        end
        if ($urandom_range(0, 3) == 0) begin
            flips = $urandom_range(0, 1) ? 0 : NUC;
        end else begin
            flips = $urandom_range(0, NUC);
        end
        return near_window(slice_base + IDX_W'($urandom_range(0, RESULT_CNT - 1)), flips);
    endfunction

    task automatic send_item(input logic mode, input logic [IDX_W-1:0] index,
                             input logic [BASES_W-1:0] guide, input logic [BASES_W-1:0] window,
                             input logic last_window);
        int gap;
        gap = draw_wait(send_stretch);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_guide_index  <= index;
        i_guide_bases  <= guide;
        i_window_bases <= window;
        i_last_window  <= last_window;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (mode == MODE_WINDOW) begin
            windows_sent++;
        end
    endtask

    task automatic send_load(input logic [IDX_W-1:0] index, input logic [BASES_W-1:0] guide);
        loaded_guide[index] = guide;
        send_item(MODE_LOAD, index, guide, rand_bases(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_window(input logic [BASES_W-1:0] window, input logic last_window);
        send_item(MODE_WINDOW, IDX_W'($urandom_range(0, STORE_GUIDES - 1)), rand_bases(),
                  window, last_window);
    endtask

    // base register changes only once the block has gone quiet
    task automatic write_base(input logic [IDX_W-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        slice_base = value;
        base_writes++;
    endtask

    initial begin : sink
        int hold;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = draw_wait(recv_stretch);
            repeat (hold) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int   chunk_len;
        int   phase_end;
        int   pick;
        logic broken;
        logic last_window;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_mode         = MODE_LOAD;
        i_guide_index  = '0;
        i_guide_bases  = '0;
        i_window_bases = '0;
        i_last_window  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every slot is loaded before any window reads the store
        for (int s = 0; s < STORE_GUIDES; s++) begin
            send_load(IDX_W'(s), rand_bases());
        end

        // base at its reset value: all-zero and all-one guides, pattern windows
        send_load('0, '0);
        send_load(IDX_W'(RESULT_CNT - 1), '1);
        send_window('0, 1'b0);
        send_window('1, 1'b1);
        send_window({NUC{2'b01}}, 1'b0);
        send_window({NUC{2'b10}}, 1'b1);
        send_window(loaded_guide[5], 1'b0);
        send_window(near_window(IDX_W'(9), 1), 1'b1);
        send_window(near_window(IDX_W'(12), NUC), 1'b0);

        // slice wraps past the top slot
        write_base('1);
        send_load('1, {NUC{2'b01}});
        send_load('0, {NUC{2'b10}});
        send_window(loaded_guide[STORE_GUIDES - 1], 1'b1);
        send_window(rand_bases(), 1'b0);
        send_window(near_window(IDX_W'(0), 2), 1'b1);

        // slice ends exactly on the top slot
        write_base(IDX_W'(STORE_GUIDES - RESULT_CNT));
        send_window(near_window('1, 3), 1'b1);
        write_base('0);
        send_window(rand_bases(), 1'b1);

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 3);
            write_base(pick == 0 ? IDX_W'(0) : pick == 1 ? '1 :
                       IDX_W'($urandom_range(0, STORE_GUIDES - 1)));
            phase_end = items_sent + $urandom_range(20, 50);
            while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
                // mostly whole chunks closed by last_window, a few left dangling
                chunk_len = $urandom_range(1, 8);
                broken    = ($urandom_range(0, 9) == 0);
                for (int w = 0; w < chunk_len; w++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_load(IDX_W'($urandom_range(0, STORE_GUIDES - 1)), rand_bases());
                    end
                    last_window = broken ? 1'($urandom_range(0, 1)) : (w == chunk_len - 1);
                    send_window(pick_window(), last_window);
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d items (%0d windows, the rest guide loads) over %0d base settings",
                 items_sent, windows_sent, base_writes + 1);
        $display("checked %0d results with random stalls on both channels, %0d failures",
                 results, failures);
        if (failures == 0 && pending == 0) begin
            $display("guide_window_mismatch_scan_top_tb OK");
        end else begin
            $display("guide_window_mismatch_scan_top_tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
sv/gwms_pkg.sv
sv/gwms_front.sv
sv/gwms_queue.sv
sv/gwms_back.sv
sv/guide_window_mismatch_scan_top.sv
dv/gwms_checker.sv
dv/guide_window_mismatch_scan_top_tb.sv
